/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* sv/tmbr_pkg.sv */
package tmbr_pkg;

	// Request kinds
	localparam logic [1:0] KIND_MAP_WR  = 2'd0;
	localparam logic [1:0] KIND_TILE_WR = 2'd1;
	localparam logic [1:0] KIND_RENDER  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;

	localparam logic [6:0] MAP_DIM_RESET = 7'd32;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Classified operation handed to the back end
	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_MAP_WR  = 3'd1,
		OP_TILE_WR = 3'd2,
		OP_RENDER  = 3'd3,
		OP_OUTSIDE = 3'd4
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [14:0] addr;   // store address, or map index for a render
		logic [15:0] data;
		logic [2:0]  col;    // column inside the tile
		logic [2:0]  row;    // row inside the tile
	} cmd_t;

endpackage

/* sv/tmbr_front.sv */
module tmbr_front #(
	parameter int MAP_ENTRIES = 4096,
	parameter int TILE_COUNT  = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         kind,
	input  logic [14:0]        address,
	input  logic [15:0]        data,
	input  logic [8:0]         pixel_x,
	input  logic [8:0]         pixel_y,
	input  logic [6:0]         map_width,
	input  logic [6:0]         map_height,
	output logic               push,
	output tmbr_pkg::cmd_t     push_cmd,
	input  logic               queue_full
);
	import tmbr_pkg::*;

	localparam int TILE_BYTES = TILE_COUNT * 32;

	logic [5:0]  tx;
	logic [5:0]  ty;
	logic [12:0] row_base;
	logic [13:0] map_idx;
	logic        outside;
	logic        accept;
	cmd_t        cmd_d;
	cmd_t        cmd_s1;
	logic        vld_s1;

	// Map coordinates of the requested pixel
	assign tx       = pixel_x[8:3];
	assign ty       = pixel_y[8:3];
	assign row_base = 13'(ty) * 13'(map_width);
	assign map_idx  = 14'(row_base) + 14'(tx);
	assign outside  = ({1'b0, tx} >= map_width) || ({1'b0, ty} >= map_height)
		|| (16'(map_idx) >= 16'(MAP_ENTRIES));

	// Classify the request
	always_comb begin
		cmd_d      = '0;
		cmd_d.data = data;
		cmd_d.col  = pixel_x[2:0];
		cmd_d.row  = pixel_y[2:0];
		cmd_d.addr = address;
		case (kind)
			KIND_MAP_WR: begin
				cmd_d.op = ({1'b0, address} < 16'(MAP_ENTRIES)) ? OP_MAP_WR : OP_NONE;
			end
			KIND_TILE_WR: begin
				cmd_d.op = ({1'b0, address} < 16'(TILE_BYTES)) ? OP_TILE_WR : OP_NONE;
			end
			KIND_RENDER: begin
				cmd_d.op   = outside ? OP_OUTSIDE : OP_RENDER;
				cmd_d.addr = 15'(map_idx);
			end
			default: begin
				cmd_d.op = OP_NONE;
			end
		endcase
	end

	// Hold the stage while the queue is full
	assign push      = vld_s1 && !queue_full;
	assign req_stall = vld_s1 && queue_full;
	assign accept    = req_valid && !req_stall;
	assign push_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

/* sv/tmbr_queue.sv */
`include "assert_macros.svh"

module tmbr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tmbr_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output tmbr_pkg::cmd_t pop_cmd,
	output logic           not_empty
);
	import tmbr_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	`CHK_IMPLY(a_no_overflow, clk, arst_n, push, !full || pop)
	`CHK_IMPLY(a_no_underflow, clk, arst_n, pop, not_empty)

endmodule

/* sv/tmbr_back.sv */
`include "assert_macros.svh"

module tmbr_back #(
	parameter int MAP_ENTRIES = 4096,
	parameter int TILE_COUNT  = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  tmbr_pkg::cmd_t q_cmd,
	output logic           pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output logic [7:0]     color_index,
	output logic           out_of_range
);
	import tmbr_pkg::*;

	localparam int TILE_BYTES = TILE_COUNT * 32;
	localparam int MAP_AW     = $clog2(MAP_ENTRIES);
	localparam int TILE_AW    = $clog2(TILE_BYTES);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_MAP  = 3'b010,
		S_TILE = 3'b100
	} bk_state_t;

	logic [15:0] map_mem  [MAP_ENTRIES];
	logic [7:0]  tile_mem [TILE_BYTES];

	bk_state_t   state_q;
	logic [15:0] map_rd_q;
	logic [7:0]  tile_rd_q;
	logic [2:0]  row_q;
	logic [2:0]  col_q;
	logic [3:0]  pal_q;
	logic        odd_q;
	logic        tile_ok_q;
	logic        out_valid_q;
	logic [7:0]  color_q;
	logic        oor_q;

	logic        out_free;
	logic [2:0]  col_f;
	logic [2:0]  row_f;
	logic [14:0] tile_addr;
	logic        tile_ok;
	logic [3:0]  nibble;

	assign out_free = !out_valid_q || !rsp_stall;
	assign pop      = q_not_empty && (state_q == S_IDLE) && out_free;

	// Mirror the in-tile position and form the tile byte address
	assign col_f     = col_q ^ {3{map_rd_q[10]}};
	assign row_f     = row_q ^ {3{map_rd_q[11]}};
	assign tile_addr = {map_rd_q[9:0], row_f, col_f[2:1]};
	assign tile_ok   = ({1'b0, map_rd_q[9:0]} < 11'(TILE_COUNT));
	assign nibble    = !tile_ok_q ? 4'd0 : (odd_q ? tile_rd_q[7:4] : tile_rd_q[3:0]);

	// Map store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (pop && q_cmd.op == OP_MAP_WR) begin
			map_mem[q_cmd.addr[MAP_AW-1:0]] <= q_cmd.data;
		end
		if (pop && q_cmd.op == OP_RENDER) begin
			map_rd_q <= map_mem[q_cmd.addr[MAP_AW-1:0]];
		end
	end

	// Tile store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (pop && q_cmd.op == OP_TILE_WR) begin
			tile_mem[q_cmd.addr[TILE_AW-1:0]] <= q_cmd.data[7:0];
		end
		if (state_q == S_MAP) begin
			tile_rd_q <= tile_mem[tile_addr[TILE_AW-1:0]];
		end
	end

	// Hold render context across the two reads
	always_ff @(posedge clk) begin
		if (pop) begin
			row_q <= q_cmd.row;
			col_q <= q_cmd.col;
		end
		if (state_q == S_MAP) begin
			pal_q     <= map_rd_q[15:12];
			odd_q     <= col_f[0];
			tile_ok_q <= tile_ok;
		end
	end

	// Sequence each command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop && q_cmd.op == OP_RENDER) begin
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					state_q <= S_TILE;
				end
				S_TILE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Raise the result flag on load, drop it once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((pop && q_cmd.op != OP_RENDER) || state_q == S_TILE) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_cmd.op != OP_RENDER) begin
			color_q <= 8'd0;
			oor_q   <= (q_cmd.op == OP_OUTSIDE);
		end else if (state_q == S_TILE) begin
			color_q <= {pal_q, nibble};
			oor_q   <= 1'b0;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign color_index  = color_q;
	assign out_of_range = oor_q;

	`CHK_IMPLY(a_busy_no_rsp, clk, arst_n, state_q != S_IDLE, !out_valid_q)
	`CHK_NEXT(a_map_then_tile, clk, arst_n, state_q == S_MAP, state_q == S_TILE)

endmodule

/* sv/tile_map_background_render.sv */
// A write passes the front stage register, the queue and the result register; a render also
// passes the back end's map read and dependent tile read, and the back end waits for both.
// Throughput: one write per cycle while the result is not stalled.
// A 2-entry command queue lets requests enter while the back end or the result waits.
// Reset (arst_n, asynchronous, active low) clears control state and sets both map
// dimensions to 32 tiles; map and tile stores are not cleared and read undefined until written.
module tile_map_background_render #(
	parameter int MAP_ENTRIES = 4096,
	parameter int TILE_COUNT  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [14:0] address,
	input  logic [15:0] data,
	input  logic [8:0]  pixel_x,
	input  logic [8:0]  pixel_y,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  color_index,
	output logic        out_of_range,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import tmbr_pkg::*;

	logic [6:0] map_width_q;
	logic [6:0] map_height_q;
	logic       push;
	cmd_t       push_cmd;
	logic       queue_full;
	logic       pop;
	cmd_t       pop_cmd;
	logic       q_not_empty;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_DIM_RESET;
			map_height_q <= MAP_DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAP_WIDTH: begin
					map_width_q <= cfg_data;
				end
				CFG_MAP_HEIGHT: begin
					map_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	tmbr_front #(
		.MAP_ENTRIES (MAP_ENTRIES),
		.TILE_COUNT  (TILE_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.kind       (kind),
		.address    (address),
		.data       (data),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.map_width  (map_width_q),
		.map_height (map_height_q),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	tmbr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (q_not_empty)
	);

	tmbr_back #(
		.MAP_ENTRIES (MAP_ENTRIES),
		.TILE_COUNT  (TILE_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_cmd        (pop_cmd),
		.pop          (pop),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.color_index  (color_index),
		.out_of_range (out_of_range)
	);

endmodule

/* tb/tb_tile_map_background_render.sv */
`timescale 1ns / 1ps

module tb_tile_map_background_render;
	import tmbr_pkg::*;

	localparam int MAP_ENTRIES   = 4096;
	localparam int TILE_COUNT    = 1024;
	localparam int TILE_BYTES    = TILE_COUNT * 32;
	localparam int CLK_PERIOD    = 4;
	localparam int LIMIT_CYCLES  = 800000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 250;
	localparam int REPORT_LIMIT  = 10;

	// Request kind and register index that the block must ignore
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED  = 2'd3;

	typedef struct packed {
		logic [7:0] color;
		logic       outside;
	} pixel_result_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  kind;
	logic [14:0] address;
	logic [15:0] data;
	logic [8:0]  pixel_x;
	logic [8:0]  pixel_y;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [7:0]  color_index;
	logic        out_of_range;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [6:0]  cfg_data;

	// Own copy of both stores and map size; predicts one pixel result per request
	class render_scoreboard;
		logic [15:0]     map_mem [MAP_ENTRIES];
		logic [7:0]      tile_mem [TILE_BYTES];
		logic [6:0]      width_tiles;
		logic [6:0]      height_tiles;
		pixel_result_t   expected_pixels [$];
		int              failures;

		function new();
			width_tiles  = MAP_DIM_RESET;
			height_tiles = MAP_DIM_RESET;
			failures     = 0;
		endfunction

		function void set_dimension(logic [1:0] idx, logic [6:0] val);
			if (idx == CFG_MAP_WIDTH)
				width_tiles = val;
			else if (idx == CFG_MAP_HEIGHT)
				height_tiles = val;
		endfunction

		function void note_request(logic [1:0] k, logic [14:0] addr, logic [15:0] wdata,
				logic [8:0] px, logic [8:0] py);
			pixel_result_t res;
			int            tx;
			int            ty;
			int            idx;
			logic [15:0]   entry;
			logic [2:0]    col;
			logic [2:0]    row;
			logic [7:0]    packed_byte;
			logic [3:0]    nibble;
			res = '0;
			case (k)
				KIND_MAP_WR: begin
					if (addr < MAP_ENTRIES)
						map_mem[addr] = wdata;
				end
				KIND_TILE_WR: begin
					if (addr < TILE_BYTES)
						tile_mem[addr] = wdata[7:0];
				end
				KIND_RENDER: begin
					tx  = int'(px[8:3]);
					ty  = int'(py[8:3]);
					idx = ty * int'(width_tiles) + tx;
					if (tx >= int'(width_tiles) || ty >= int'(height_tiles) ||
							idx >= MAP_ENTRIES) begin
						res.outside = 1'b1;
					end else begin
						entry  = map_mem[idx];
						col    = entry[10] ? ~px[2:0] : px[2:0];
						row    = entry[11] ? ~py[2:0] : py[2:0];
						nibble = 4'h0;
						// Two pixels per byte, low nibble is the even column
						if (int'(entry[9:0]) < TILE_COUNT) begin
							packed_byte = tile_mem[int'(entry[9:0]) * 32 + int'(row) * 4 +
								int'(col[2:1])];
							nibble = col[0] ? packed_byte[7:4] : packed_byte[3:0];
						end
						res.color = {entry[15:12], nibble};
					end
				end
				default: ;
			endcase
			expected_pixels.push_back(res);
		endfunction

		function void check_pixel(logic [7:0] color, logic outside);
			pixel_result_t want;
			if (expected_pixels.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: color %02h outside %0b", color, outside);
				return;
			end
			want = expected_pixels.pop_front();
			if (color !== want.color || outside !== want.outside) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("mismatch: expected color %02h outside %0b, got color %02h outside %0b",
						want.color, want.outside, color, outside);
			end
		endfunction
	endclass

	render_scoreboard render_chk = new();

	// Stimulus bookkeeping: which entries hold data, and what the map holds
	bit          map_written [MAP_ENTRIES];
	bit          tile_written [TILE_BYTES];
	logic [15:0] map_shadow [MAP_ENTRIES];
	int          width_now;
	int          height_now;
	int          sent;
	int          send_calm;
	bit          quiet;

	tile_map_background_render #(
		.MAP_ENTRIES(MAP_ENTRIES),
		.TILE_COUNT(TILE_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.address(address),
		.data(data),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.color_index(color_index),
		.out_of_range(out_of_range),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Observe accepted requests, results and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				render_chk.note_request(kind, address, data, pixel_x, pixel_y);
			if (rsp_valid && !rsp_stall)
				render_chk.check_pixel(color_index, out_of_range);
			if (cfg_valid && cfg_ready)
				render_chk.set_dimension(cfg_index, cfg_data);
		end
	end

	// Stall the result side in bursts, with calm stretches between
	initial begin : stall_gen
		int burst;
		int calm;
		rsp_stall = 1'b0;
		burst     = 0;
		calm      = 0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				rsp_stall = 1'b0;
			end else if (burst > 0) begin
				rsp_stall = 1'b1;
				burst--;
			end else if (calm > 0) begin
				rsp_stall = 1'b0;
				calm--;
			end else if ($urandom_range(0, 1) == 1) begin
				rsp_stall = 1'b1;
				burst     = $urandom_range(0, 8);
			end else begin
				rsp_stall = 1'b0;
				calm      = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 12) :
					$urandom_range(40, 150);
			end
		end
	end

	// Present one request, with an optional gap, and hold it until accepted
	task automatic send_request(input logic [1:0] k, input logic [14:0] addr,
			input logic [15:0] wdata, input logic [8:0] px, input logic [8:0] py);
		int gap;
		@(negedge clk);
		if (!quiet) begin
			if (send_calm > 0) begin
				send_calm--;
			end else if ($urandom_range(0, 3) == 0) begin
				gap       = $urandom_range(1, 9);
				req_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end else if ($urandom_range(0, 9) == 0) begin
				send_calm = $urandom_range(20, 80);
			end
		end
		req_valid = 1'b1;
		kind      = k;
		address   = addr;
		data      = wdata;
		pixel_x   = px;
		pixel_y   = py;
		do
			@(posedge clk);
		while (req_stall);
		sent++;
	endtask

	task automatic write_map(input logic [14:0] addr, input logic [15:0] wdata);
		if (addr < MAP_ENTRIES) begin
			map_written[addr] = 1'b1;
			map_shadow[addr]  = wdata;
		end
		send_request(KIND_MAP_WR, addr, wdata, 9'($urandom), 9'($urandom));
	endtask

	task automatic write_tile(input logic [14:0] addr, input logic [15:0] wdata);
		tile_written[addr] = 1'b1;
		send_request(KIND_TILE_WR, addr, wdata, 9'($urandom), 9'($urandom));
	endtask

	// Render a pixel; fill the map entry and tile byte it reads first if still empty
	task automatic render_pixel(input int x, input int y);
		int          tx;
		int          ty;
		int          idx;
		int          col;
		int          row;
		int          byte_addr;
		logic [15:0] entry;
		tx  = x / 8;
		ty  = y / 8;
		idx = ty * width_now + tx;
		if (tx < width_now && ty < height_now && idx < MAP_ENTRIES) begin
			if (!map_written[idx])
				write_map(15'(idx), 16'($urandom));
			entry     = map_shadow[idx];
			col       = entry[10] ? 7 - (x % 8) : x % 8;
			row       = entry[11] ? 7 - (y % 8) : y % 8;
			byte_addr = int'(entry[9:0]) * 32 + row * 4 + col / 2;
			if (int'(entry[9:0]) < TILE_COUNT && !tile_written[byte_addr])
				write_tile(15'(byte_addr), 16'($urandom));
		end
		send_request(KIND_RENDER, 15'($urandom), 16'($urandom), 9'(x), 9'(y));
	endtask

	// Drop valid, wait for every expected pixel, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		req_valid = 1'b0;
		while (render_chk.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dimension(input logic [1:0] idx, input logic [6:0] val);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == CFG_MAP_WIDTH)
			width_now = int'(val);
		else if (idx == CFG_MAP_HEIGHT)
			height_now = int'(val);
	endtask

	// Coordinate mostly inside the configured map, sometimes anywhere
	function automatic int pick_coord(input int tiles);
		int span;
		if (tiles == 0 || $urandom_range(0, 4) == 0)
			return $urandom_range(0, 511);
		span = (tiles * 8 > 512) ? 512 : tiles * 8;
		return $urandom_range(0, span - 1);
	endfunction

	initial begin
		#(longint'(LIMIT_CYCLES) * CLK_PERIOD);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : main_seq
		int phase_w [PHASES];
		int phase_h [PHASES];
		int p;
		int k;
		int goal;
		int choice;
		int x0;
		int y0;
		int run_len;
		phase_w = '{1, 64, 0, 127, 64, 1, -1, 32};
		phase_h = '{1, 64, 5, 127, 0, 64, -1, 32};
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		kind       = KIND_MAP_WR;
		address    = '0;
		data       = '0;
		pixel_x    = '0;
		pixel_y    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_MAP_WIDTH;
		cfg_data   = '0;
		width_now  = int'(MAP_DIM_RESET);
		height_now = int'(MAP_DIM_RESET);
		sent       = 0;
		send_calm  = 0;
		quiet      = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Both flips, last tile, last byte of the tile store, upper data bits dropped
		write_map(15'd0, 16'hFFFF);
		write_tile(15'h7FFF, 16'hFFA5);
		render_pixel(0, 0);
		render_pixel(1, 0);
		// No flips, tile zero, palette zero
		write_map(15'd1, 16'h0000);
		write_tile(15'd0, 16'h0012);
		render_pixel(8, 0);
		render_pixel(9, 0);
		// Horizontal flip only, then vertical flip only
		write_map(15'd2, 16'h1400);
		write_tile(15'd3, 16'h00C0);
		render_pixel(16, 0);
		write_map(15'd3, 16'h2800);
		write_tile(15'd28, 16'h0007);
		render_pixel(24, 0);
		// Map writes past the store are ignored
		write_map(15'h7FFF, 16'h1234);
		write_map(15'(MAP_ENTRIES), 16'hABCD);
		render_pixel(0, 0);
		// Unused kind with every field bit set
		send_request(KIND_UNUSED, 15'h7FFF, 16'hFFFF, 9'h1FF, 9'h1FF);
		// Pixels just outside and at the far corner of the map
		render_pixel(511, 511);
		render_pixel(256, 0);
		render_pixel(0, 256);
		render_pixel(255, 255);

		// Random phases, one map size each, registers written while idle
		for (p = 0; p < PHASES; p++) begin
			if (p == 3)
				write_dimension(CFG_UNUSED, 7'h7F);
			write_dimension(CFG_MAP_WIDTH,
				7'((phase_w[p] < 0) ? $urandom_range(1, 64) : phase_w[p]));
			write_dimension(CFG_MAP_HEIGHT,
				7'((phase_h[p] < 0) ? $urandom_range(1, 64) : phase_h[p]));
			if (p == PHASES - 1)
				quiet = 1'b1;
			goal = sent + PHASE_ITEMS;
			while (sent < goal) begin
				choice = $urandom_range(0, 99);
				if (choice < 50) begin
					render_pixel(pick_coord(width_now), pick_coord(height_now));
				end else if (choice < 60) begin
					// Scan a run of pixels along one row
					x0      = pick_coord(width_now);
					y0      = pick_coord(height_now);
					run_len = $urandom_range(4, 16);
					for (k = 0; k < run_len; k++)
						render_pixel((x0 + k) % 512, y0);
				end else if (choice < 68) begin
					render_pixel($urandom_range(0, 511), $urandom_range(0, 511));
				end else if (choice < 79) begin
					write_map(15'($urandom_range(0, MAP_ENTRIES - 1)), 16'($urandom));
				end else if (choice < 82) begin
					write_map(15'($urandom), 16'($urandom));
				end else if (choice < 95) begin
					write_tile(15'($urandom), 16'($urandom));
				end else begin
					send_request(KIND_UNUSED, 15'($urandom), 16'($urandom),
						9'($urandom), 9'($urandom));
				end
			end
		end

		drain();
		if (render_chk.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
